[rtl/core/assert_macros.svh]
// Assertion macros for the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define RBF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define RBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rbf_pkg.sv]
// Types, constants and helper functions for the range bloom filter.
package rbf_pkg;

    localparam int TABLE_BYTES_DEF = 64;
    localparam int MAX_ROUNDS      = 8;
    localparam int Q_DEPTH         = 2;
    localparam int QAW             = $clog2(Q_DEPTH);

    localparam logic [3:0]  NUM_HASHES_RST = 4'd4;
    localparam logic [3:0]  ROUNDS_MAX     = 4'(MAX_ROUNDS);

    localparam logic [63:0] MM_SEED  = 64'h0000_0000_97c2_9b3a;
    localparam logic [63:0] MM_LEN   = 64'd4;
    localparam logic [63:0] MM_C1    = 64'h87c3_7b91_1142_53d5;
    localparam logic [63:0] MM_C2    = 64'h4cf5_ad43_2745_937f;
    localparam logic [63:0] MIX_F    = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] MIX_C    = 64'hc4ce_b9fe_1a85_ec53;
    localparam logic [63:0] MM_B0    = MM_SEED ^ MM_LEN;
    localparam logic [63:0] MM_B0X2  = {MM_B0[62:0], 1'b0};

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] key;
        logic [3:0]  rounds;
    } t_item;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctrl;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } t_state;

    function automatic logic [31:0] round_salt(input logic [2:0] r);
        logic [31:0] s;
        unique case (r)
            3'd0: s = 32'hAAAA_AAAA;
            3'd1: s = 32'h5555_5555;
            3'd2: s = 32'h3333_3333;
            3'd3: s = 32'hCCCC_CCCC;
            3'd4: s = 32'h6666_6666;
            3'd5: s = 32'h9999_9999;
            3'd6: s = 32'hB5B5_B5B5;
            3'd7: s = 32'h4B4B_4B4B;
            default: s = 32'hAAAA_AAAA;
        endcase
        return s;
    endfunction

    function automatic logic [5:0] round_sq(input logic [2:0] r);
        return 6'({3'b0, r} * {3'b0, r});
    endfunction

    function automatic logic [8:0] round_cube(input logic [2:0] r);
        return 9'({3'b0, round_sq(r)} * {6'b0, r});
    endfunction

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return {32'b0, a} * {32'b0, b};
    endfunction

endpackage

[rtl/core/rbf_front.sv]
// Front end: input accept, round count register and item queue.
module rbf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic [31:0]        i_key,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    input  rbf_pkg::t_back_ctrl i_ctrl,
    output rbf_pkg::t_item     o_item,
    output logic               o_item_valid
);
    import rbf_pkg::*;

    logic [3:0]   r_num_hashes;
    t_item        r_q [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0] r_cnt;
    logic         accept;
    logic         pop;
    t_item        in_item;

    assign o_cfg_ready  = 1'b1;
    assign o_stall      = (r_cnt == (QAW+1)'(Q_DEPTH)) || i_ctrl.clearing;
    assign accept       = i_valid && !o_stall;
    assign o_item_valid = (r_cnt != '0);
    assign pop          = i_ctrl.pop && o_item_valid;
    assign o_item       = r_q[r_rp];

    always_comb begin
        in_item.func   = i_func;
        in_item.key    = i_key;
        in_item.rounds = (r_num_hashes > ROUNDS_MAX) ? ROUNDS_MAX : r_num_hashes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_hashes <= NUM_HASHES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_hashes <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (accept && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !accept) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= in_item;
        end
    end

endmodule

[rtl/core/rbf_hash.sv]
// Pipelined hash: MurmurHash3 of the key, AP-hash mixing, bit address.
module rbf_hash #(
    parameter int AW = 9,
    parameter int TABLE_BITS = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_key,
    input  logic [2:0]    i_round,
    output logic          o_valid,
    output logic [AW-1:0] o_addr
);
    import rbf_pkg::*;

    localparam int NS = 13;
    localparam int NR = 11;
    localparam logic [AW-1:0] ADDR_MASK = AW'(TABLE_BITS - 1);

    function automatic logic [63:0] xs33(input logic [63:0] x);
        return x ^ {33'b0, x[63:33]};
    endfunction

    function automatic logic [63:0] fold(input logic [63:0] p0, input logic [31:0] p1,
                                         input logic [31:0] p2);
        logic [31:0] hi;
        hi = p1 + p2;
        return p0 + {hi, 32'b0};
    endfunction

    function automatic logic [31:0] ap_round(input logic [31:0] w, input logic [31:0] h);
        return h ^ ~((h << 11) + (w ^ (h >> 5)));
    endfunction

    logic [NS-1:0] r_vld;
    logic [2:0]    r_rnd [NR];
    logic [63:0]   r_p0;
    logic [31:0]   r_p1;
    logic [63:0]   r_k;
    logic [63:0]   r_q0;
    logic [31:0]   r_q1, r_q2;
    logic [63:0]   r_a0;
    logic [63:0]   r_ma, r_mb;
    logic [63:0]   r_fa0, r_fb0;
    logic [31:0]   r_fa1, r_fa2, r_fb1, r_fb2;
    logic [63:0]   r_ga, r_gb;
    logic [63:0]   r_ha0, r_hb0;
    logic [31:0]   r_ha1, r_ha2, r_hb1, r_hb2;
    logic [63:0]   r_a3, r_b3;
    logic [63:0]   r_wa, r_wb;
    logic [31:0]   r_ap [4];
    logic [31:0]   r_t [4];
    logic [AW-1:0] r_addr;
    logic [31:0]   salt;
    logic [31:0]   sum;
    logic [63:0]   k_sum;

    assign salt  = round_salt(r_rnd[NR-2]);
    assign sum   = r_t[0] + r_t[1] + r_t[2] + r_t[3];
    assign k_sum = r_p0 + {r_p1, 32'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd[0] <= i_round;
        for (int i = 1; i < NR; i++) begin
            r_rnd[i] <= r_rnd[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0  <= mul32(i_key, MM_C1[31:0]);
        r_p1  <= i_key * MM_C1[63:32];
        r_k   <= {k_sum[32:0], k_sum[63:33]};
        r_q0  <= mul32(r_k[31:0], MM_C2[31:0]);
        r_q1  <= r_k[31:0] * MM_C2[63:32];
        r_q2  <= r_k[63:32] * MM_C2[31:0];
        r_a0  <= MM_B0 ^ fold(r_q0, r_q1, r_q2);
        r_ma  <= xs33(r_a0 + MM_B0);
        r_mb  <= xs33(r_a0 + MM_B0X2);
        r_fa0 <= mul32(r_ma[31:0], MIX_F[31:0]);
        r_fa1 <= r_ma[31:0] * MIX_F[63:32];
        r_fa2 <= r_ma[63:32] * MIX_F[31:0];
        r_fb0 <= mul32(r_mb[31:0], MIX_F[31:0]);
        r_fb1 <= r_mb[31:0] * MIX_F[63:32];
        r_fb2 <= r_mb[63:32] * MIX_F[31:0];
        r_ga  <= xs33(fold(r_fa0, r_fa1, r_fa2));
        r_gb  <= xs33(fold(r_fb0, r_fb1, r_fb2));
        r_ha0 <= mul32(r_ga[31:0], MIX_C[31:0]);
        r_ha1 <= r_ga[31:0] * MIX_C[63:32];
        r_ha2 <= r_ga[63:32] * MIX_C[31:0];
        r_hb0 <= mul32(r_gb[31:0], MIX_C[31:0]);
        r_hb1 <= r_gb[31:0] * MIX_C[63:32];
        r_hb2 <= r_gb[63:32] * MIX_C[31:0];
        r_a3  <= xs33(fold(r_ha0, r_ha1, r_ha2));
        r_b3  <= xs33(fold(r_hb0, r_hb1, r_hb2));
        r_wa  <= r_a3 + r_b3;
        r_wb  <= r_a3 + {r_b3[62:0], 1'b0};
        r_ap[0] <= ap_round(r_wa[31:0], salt);
        r_ap[1] <= ap_round(r_wa[63:32], salt);
        r_ap[2] <= ap_round(r_wb[31:0], salt);
        r_ap[3] <= ap_round(r_wb[63:32], salt);
        r_t[0]  <= r_ap[0];
        r_t[1]  <= r_ap[1] * {29'b0, r_rnd[NR-1]};
        r_t[2]  <= r_ap[2] * {26'b0, round_sq(r_rnd[NR-1])};
        r_t[3]  <= r_ap[3] * {23'b0, round_cube(r_rnd[NR-1])};
        r_addr  <= sum[AW-1:0] & ADDR_MASK;
    end

    assign o_valid = r_vld[NS-1];
    assign o_addr  = r_addr;

endmodule

[rtl/core/rbf_back.sv]
// Back end: round sequencer, bit store with clear pass, result register.
`include "assert_macros.svh"

module rbf_back #(
    parameter int TABLE_BITS = 512,
    parameter int AW = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbf_pkg::t_item      i_item,
    input  logic                i_item_valid,
    output rbf_pkg::t_back_ctrl o_ctrl,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_present
);
    import rbf_pkg::*;

    localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_BITS - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr;
    t_item         r_item;
    logic [3:0]    r_issue;
    logic [3:0]    r_ret;
    logic          r_rd_valid;
    logic          r_miss;
    logic          r_out_valid;
    logic          r_present;
    logic          r_mem [TABLE_BITS];
    logic          r_rdata;

    logic          start;
    logic          issue;
    logic          finish;
    logic          mem_we;
    logic          mem_wd;
    logic [AW-1:0] mem_addr;
    logic          h_valid;
    logic [AW-1:0] h_addr;
    logic [31:0]   h_key;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_item_valid && !r_out_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        start    = (r_state == ST_IDLE) && i_item_valid && !r_out_valid;
        issue    = (r_state == ST_RUN) && (r_issue < r_item.rounds);
        finish   = (r_state == ST_RUN) && (r_ret == r_item.rounds) && !r_rd_valid;
        mem_we   = 1'b0;
        mem_wd   = 1'b0;
        mem_addr = '0;
        if (r_state == ST_CLEAR) begin
            mem_we   = 1'b1;
            mem_addr = r_clr;
        end else if (h_valid) begin
            mem_we   = (r_item.func == FUNC_INSERT);
            mem_wd   = 1'b1;
            mem_addr = h_addr;
        end
    end

    assign h_key = r_item.key >> r_issue[2:0];

    rbf_hash #(
        .AW         (AW),
        .TABLE_BITS (TABLE_BITS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_key   (h_key),
        .i_round (r_issue[2:0]),
        .o_valid (h_valid),
        .o_addr  (h_addr)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_item <= i_item;
        end
        if (finish) begin
            r_present <= (r_item.func == FUNC_QUERY) && !r_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_issue     <= '0;
            r_ret       <= '0;
            r_rd_valid  <= 1'b0;
            r_miss      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= h_valid && (r_state == ST_RUN) && (r_item.func == FUNC_QUERY);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (start) begin
                r_issue <= '0;
                r_ret   <= '0;
                r_miss  <= 1'b0;
            end else begin
                if (issue) begin
                    r_issue <= r_issue + 1'b1;
                end
                if (h_valid) begin
                    r_ret <= r_ret + 1'b1;
                end
                if (r_rd_valid && !r_rdata) begin
                    r_miss <= 1'b1;
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ctrl.pop      = start;
    assign o_ctrl.clearing = (r_state == ST_CLEAR);
    assign o_valid         = r_out_valid;
    assign o_present       = r_present;

    `RBF_ASSERT(a_issue_bound, (r_state == ST_RUN) |-> (r_issue <= r_item.rounds), "issue count past round count")
    `RBF_ASSERT(a_hash_in_run, h_valid |-> (r_state == ST_RUN), "hash result outside an item")
    `RBF_ASSERT_NEXT(a_start_clean, start, (r_issue == 4'd0) && (r_ret == 4'd0) && !r_miss, "item started with stale counters")

endmodule

[rtl/core/range_bloom_filter_32bit_unit.sv]
// Top level of the 32-bit key bloom filter.
//
//  channel  direction  handshake                 word
//  in       sink       i_valid / o_stall         i_func, i_key
//  out      source     o_valid / i_stall         o_present
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_data (num_hashes)
//
// One round of an item enters the 13-stage hash pipeline per cycle, then each round
// makes one bit store access (a query also registers the bit it reads), and the
// result is registered into o_present and o_valid.
// Reset starts a clear pass over all TABLE_BYTES*8 bits (512 by default) with o_stall high.
// A two-word queue lets inputs arrive while the back end works or o_valid is held.
module range_bloom_filter_32bit_unit #(
    parameter int TABLE_BYTES = rbf_pkg::TABLE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [31:0] i_key,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_present,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    import rbf_pkg::*;

    localparam int TABLE_BITS = TABLE_BYTES * 8;
    localparam int AW = $clog2(TABLE_BITS);

    t_item      item;
    logic       item_valid;
    t_back_ctrl ctrl;

    rbf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_key        (i_key),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_ctrl       (ctrl),
        .o_item       (item),
        .o_item_valid (item_valid)
    );

    rbf_back #(
        .TABLE_BITS (TABLE_BITS),
        .AW         (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_ctrl       (ctrl),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_present    (o_present)
    );

endmodule

[tb/range_bloom_filter_32bit_checker.sv]
// Checker for the bloom filter: predicts each answer and compares the output words.
module range_bloom_filter_32bit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        i_func,
    input  logic [31:0] i_key,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic        o_present,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    output int          fail_count,
    output int          pending_count,
    output int          answers_seen
);
    import rbf_pkg::*;

    localparam int TBL_BITS = TABLE_BYTES_DEF * 8;

    logic [TBL_BITS-1:0] shadow_bits;
    logic [3:0]          hash_count;
    logic                answer_q[$];

    function automatic logic [63:0] fmix64(input logic [63:0] v);
        logic [63:0] t;
        t = v;
        t = t ^ (t >> 33);
        t = t * MIX_F;
        t = t ^ (t >> 33);
        t = t * MIX_C;
        t = t ^ (t >> 33);
        return t;
    endfunction

    function automatic logic [31:0] ap_mix(input logic [31:0] w, input logic [31:0] h);
        return h ^ ~((h << 11) + (w ^ (h >> 5)));
    endfunction

    function automatic int unsigned sel_bit(input logic [31:0] key, input int unsigned r);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] k;
        logic [31:0] w0, w1, w2, w3, salt, rr, h;
        logic [31:0] salts [0:7];
        salts = '{32'hAAAAAAAA, 32'h55555555, 32'h33333333, 32'hCCCCCCCC,
                  32'h66666666, 32'h99999999, 32'hB5B5B5B5, 32'h4B4B4B4B};
        k = {32'b0, key >> r};
        k = k * MM_C1;
        k = {k[32:0], k[63:33]};
        k = k * MM_C2;
        a = MM_SEED ^ k ^ MM_LEN;
        b = MM_SEED ^ MM_LEN;
        a = a + b;
        b = b + a;
        a = fmix64(a);
        b = fmix64(b);
        a = a + b;
        b = b + a;
        salt = salts[r & 7];
        w0 = ap_mix(a[31:0], salt);
        w1 = ap_mix(a[63:32], salt);
        w2 = ap_mix(b[31:0], salt);
        w3 = ap_mix(b[63:32], salt);
        rr = r;
        h = w0 + rr * w1 + rr * rr * w2 + rr * rr * rr * w3;
        return h & (TBL_BITS - 1);
    endfunction

    always @(posedge i_clk) begin
        int unsigned rounds;
        int unsigned idx;
        logic        hit;
        logic        want;
        if (!i_rst_n) begin
            shadow_bits   = '0;
            hash_count    <= NUM_HASHES_RST;
            answer_q.delete();
            fail_count    <= 0;
            pending_count <= 0;
            answers_seen  <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                answers_seen <= answers_seen + 1;
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual present=%0b",
                             $time, o_present);
                    fail_count <= fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (o_present !== want) begin
                        $display("%0t: present mismatch, expected %0b, actual %0b",
                                 $time, want, o_present);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                rounds = (hash_count > ROUNDS_MAX) ? MAX_ROUNDS : hash_count;
                hit = 1'b1;
                for (int unsigned r = 0; r < rounds; r++) begin
                    idx = sel_bit(i_key, r);
                    if (i_func == FUNC_QUERY) begin
                        if (!shadow_bits[idx]) hit = 1'b0;
                    end else begin
                        shadow_bits[idx] = 1'b1;
                    end
                end
                answer_q.push_back((i_func == FUNC_QUERY) && hit);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                hash_count <= i_cfg_data;
            end
            pending_count <= answer_q.size();
        end
    end
endmodule

[tb/range_bloom_filter_32bit_unit_tb.sv]
// Testbench top: drives inserts, queries and hash-count writes, and gives the verdict.
module range_bloom_filter_32bit_unit_tb;
    import rbf_pkg::*;

    localparam int WATCH_LIMIT = 5000;
    localparam int SETTLE      = 40;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_func      = FUNC_INSERT;
    logic [31:0] i_key       = '0;
    logic        i_stall     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [3:0]  i_cfg_data  = '0;
    logic        o_stall, o_valid, o_present, o_cfg_ready;

    int          fail_count, pending_count, answers_seen;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;
    logic [31:0] key_pool[$];

    always #5 i_clk = ~i_clk;

    range_bloom_filter_32bit_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_func(i_func), .i_key(i_key),
        .o_valid(o_valid), .i_stall(i_stall), .o_present(o_present),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    range_bloom_filter_32bit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_func(i_func), .i_key(i_key),
        .o_valid(o_valid), .i_stall(i_stall), .o_present(o_present),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .answers_seen(answers_seen)
    );

    // hold off the output side for a drawn number of cycles after each word
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (o_valid && !i_stall) stall_left <= calm ? 0 : $urandom_range(0, 5);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_word(input logic func, input logic [31:0] key);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func  <= func;
        i_key   <= key;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (func == FUNC_INSERT) key_pool.push_back(key);
    endtask

    task automatic drain();
        if (i_valid) i_valid <= 1'b0;
        while (pending_count != 0 || o_valid) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_hashes(input logic [3:0] value);
        drain();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        logic [31:0] key;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                key = $urandom();
                send_word(FUNC_INSERT, key);
            end else if (pick < 70 && key_pool.size() > 0) begin
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                if ($urandom_range(0, 3) == 0) key = key ^ (32'd1 << $urandom_range(0, 31));
                send_word(FUNC_QUERY, key);
            end else begin
                key = $urandom();
                send_word(FUNC_QUERY, key);
            end
        end
    endtask

    initial begin
        logic [3:0] settings [0:5];
        settings = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd3, 4'd6};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_hashes(4'd8);
        send_word(FUNC_QUERY,  32'h0000_0000);
        send_word(FUNC_INSERT, 32'h0000_0000);
        send_word(FUNC_QUERY,  32'h0000_0000);
        send_word(FUNC_INSERT, 32'hFFFF_FFFF);
        send_word(FUNC_QUERY,  32'hFFFF_FFFF);
        send_word(FUNC_QUERY,  32'h8000_0000);
        send_word(FUNC_INSERT, 32'h8000_0000);
        send_word(FUNC_QUERY,  32'h8000_0000);
        send_word(FUNC_QUERY,  32'h0000_0001);
        send_word(FUNC_INSERT, 32'hAAAA_5555);
        send_word(FUNC_QUERY,  32'hAAAA_5555);
        send_word(FUNC_QUERY,  32'h5555_AAAA);
        write_hashes(4'd0);
        send_word(FUNC_QUERY,  32'h1234_5678);
        send_word(FUNC_INSERT, 32'h1234_5678);
        send_word(FUNC_QUERY,  32'hDEAD_BEEF);
        write_hashes(4'd15);
        send_word(FUNC_QUERY,  32'h0000_0000);
        send_word(FUNC_INSERT, 32'h7FFF_FFFF);
        send_word(FUNC_QUERY,  32'h7FFF_FFFF);
        write_hashes(4'd1);
        send_word(FUNC_QUERY,  32'h0000_0000);
        send_word(FUNC_QUERY,  32'hFFFF_FFFE);

        for (int p = 0; p < 6; p++) begin
            write_hashes(settings[p]);
            calm = (p == 2);
            random_phase(75);
            write_hashes(4'($urandom_range(0, 15)));
            random_phase(75);
        end
        calm = 1'b0;
        drain();

        $display("covered %0d words in, %0d answers out, hash counts 0 to 15 incl. saturation",
                 items_sent, answers_seen);
        if (fail_count == 0 && pending_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
